// File: hw/rtl/pfs_pkg.sv
// Package for the priority failover selector.
// Holds widths, event and register codes, and controller types shared by all files.
`timescale 1ns / 1ps
package pfs_pkg;

  localparam int MAX_PROVIDERS = 8;

  localparam int IDX_W       = 3;
  localparam int NUM_ENTRIES = 1 << IDX_W;
  localparam int PRIO_SLOTS  = 8;
  localparam int SLOT_W      = 3;
  localparam int RUN_W       = 8;
  localparam int SUM_W       = 32;
  localparam int THR_W       = 8;
  localparam int PCNT_W      = 4;
  localparam int PRIO_W      = PRIO_SLOTS * IDX_W;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [THR_W-1:0]  THR_RESET  = 8'd3;
  localparam logic [PCNT_W-1:0] PCNT_RESET = 4'd0;
  localparam logic [PRIO_W-1:0] PRIO_RESET = 24'hFAC688;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY  = 2'd2;

  typedef enum logic [1:0] {
    KIND_SUCCESS   = 2'd0,
    KIND_FAILURE   = 2'd1,
    KIND_RESET_ONE = 2'd2,
    KIND_RESET_ALL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic trigger;
    logic scan_hit;
    logic scan_last;
  } sts_t;

endpackage

// File: hw/rtl/pfs_evt_if.sv
// Request channel of the priority failover selector: one health event.
// Depends on pfs_pkg for field widths.
`timescale 1ns / 1ps
interface pfs_evt_if;
  import pfs_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [IDX_W-1:0] provider_index;

  modport source (output valid, output kind, output provider_index, input ready);
  modport sink (input valid, input kind, input provider_index, output ready);
endinterface

// File: hw/rtl/pfs_res_if.sv
// Result channel of the priority failover selector: one result per request.
// Depends on pfs_pkg for field widths.
`timescale 1ns / 1ps
interface pfs_res_if;
  import pfs_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] active_provider;
  logic             switched;
  logic [IDX_W-1:0] previous_provider;
  logic             known;
  logic [RUN_W-1:0] run_of_failures;
  logic [SUM_W-1:0] failures_total;
  logic [SUM_W-1:0] successes_total;

  modport source (output valid, output active_provider, output switched,
                  output previous_provider, output known, output run_of_failures,
                  output failures_total, output successes_total, input ready);
  modport sink (input valid, input active_provider, input switched,
                input previous_provider, input known, input run_of_failures,
                input failures_total, input successes_total, output ready);
endinterface

// File: hw/rtl/pfs_ctrl.sv
// Controller of the priority failover selector: sequences capture, update,
// priority scan and result hand-off. Depends on pfs_pkg.
`timescale 1ns / 1ps
module pfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  pfs_pkg::sts_t sts,
  output pfs_pkg::cmd_t cmd
);
  import pfs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = sts.trigger ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (sts.scan_hit || sts.scan_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_UPDATE: cmd.update = 1'b1;
      ST_SCAN:   cmd.scan = 1'b1;
      ST_DONE:   cmd.emit = out_free;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/pfs_dpath.sv
// Datapath of the priority failover selector: configuration registers, per-provider
// counters, active provider, scan slot counter and result register. Depends on pfs_pkg.
`timescale 1ns / 1ps
module pfs_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                     in_kind,
  input  logic [pfs_pkg::IDX_W-1:0]      in_provider_index,
  input  pfs_pkg::cmd_t                  cmd,
  output pfs_pkg::sts_t                  sts,
  output logic [pfs_pkg::IDX_W-1:0]      res_active,
  output logic                           res_switched,
  output logic [pfs_pkg::IDX_W-1:0]      res_previous,
  output logic                           res_known,
  output logic [pfs_pkg::RUN_W-1:0]      res_run,
  output logic [pfs_pkg::SUM_W-1:0]      res_fsum,
  output logic [pfs_pkg::SUM_W-1:0]      res_ssum
);
  import pfs_pkg::*;

  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_PROVIDERS);
  localparam logic [RUN_W-1:0]  RUN_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX = '1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PRIO_SLOTS - 1);

  logic [THR_W-1:0]  thr_r;
  logic [PCNT_W-1:0] pcnt_r;
  logic [PRIO_W-1:0] prio_r;

  logic [RUN_W-1:0] run_r  [NUM_ENTRIES];
  logic [SUM_W-1:0] fsum_r [NUM_ENTRIES];
  logic [SUM_W-1:0] ssum_r [NUM_ENTRIES];

  logic [IDX_W-1:0]  active_r;
  logic [IDX_W-1:0]  prev_r;
  logic [IDX_W-1:0]  idx_r;
  kind_t             kind_r;
  logic              known_r;
  logic [SLOT_W-1:0] slot_r;

  logic [CNT_W-1:0] live_cnt;
  logic [IDX_W-1:0] cand;
  logic [IDX_W-1:0] rd_addr;
  logic [RUN_W-1:0] rd_run;
  logic [SUM_W-1:0] rd_fsum;
  logic [SUM_W-1:0] rd_ssum;
  logic [RUN_W-1:0] run_inc;
  logic [SUM_W-1:0] fsum_inc;
  logic [SUM_W-1:0] ssum_inc;

  assign live_cnt = ({1'b0, pcnt_r} > MAX_CNT) ? MAX_CNT : {1'b0, pcnt_r};
  assign cand     = prio_r[IDX_W*slot_r +: IDX_W];
  assign rd_addr  = cmd.scan ? cand : idx_r;
  assign rd_run   = run_r[rd_addr];
  assign rd_fsum  = fsum_r[rd_addr];
  assign rd_ssum  = ssum_r[rd_addr];
  assign run_inc  = (rd_run == RUN_MAX) ? rd_run : rd_run + 1'b1;
  assign fsum_inc = (rd_fsum == SUM_MAX) ? rd_fsum : rd_fsum + 1'b1;
  assign ssum_inc = (rd_ssum == SUM_MAX) ? rd_ssum : rd_ssum + 1'b1;

  always_comb begin
    sts.trigger   = (kind_r == KIND_FAILURE) && known_r && (run_inc >= thr_r) &&
                    (idx_r == active_r);
    sts.scan_hit  = (CNT_W'(cand) < live_cnt) && (cand != idx_r) && (rd_run < thr_r);
    sts.scan_last = (slot_r == LAST_SLOT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      pcnt_r <= PCNT_RESET;
      prio_r <= PRIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        REG_COUNT:     pcnt_r <= cfg_data[PCNT_W-1:0];
        REG_PRIORITY:  prio_r <= cfg_data[PRIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        run_r[i]  <= '0;
        fsum_r[i] <= '0;
        ssum_r[i] <= '0;
      end
    end else if (cmd.update) begin
      if (kind_r == KIND_RESET_ALL) begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          run_r[i]  <= '0;
          fsum_r[i] <= '0;
          ssum_r[i] <= '0;
        end
      end else if (known_r) begin
        case (kind_r)
          KIND_SUCCESS: begin
            run_r[idx_r]  <= '0;
            ssum_r[idx_r] <= ssum_inc;
          end
          KIND_FAILURE: begin
            run_r[idx_r]  <= run_inc;
            fsum_r[idx_r] <= fsum_inc;
          end
          KIND_RESET_ONE: begin
            run_r[idx_r]  <= '0;
            fsum_r[idx_r] <= '0;
            ssum_r[idx_r] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      slot_r   <= '0;
    end else begin
      if (cmd.update) slot_r <= '0;
      if (cmd.scan) begin
        slot_r <= slot_r + 1'b1;
        if (sts.scan_hit) active_r <= cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind_t'(in_kind);
      idx_r   <= in_provider_index;
      prev_r  <= active_r;
      known_r <= CNT_W'(in_provider_index) < live_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_active   <= active_r;
      res_switched <= (active_r != prev_r);
      res_previous <= prev_r;
      res_known    <= known_r;
      res_run      <= known_r ? rd_run : '0;
      res_fsum     <= known_r ? rd_fsum : '0;
      res_ssum     <= known_r ? rd_ssum : '0;
    end
  end

endmodule

// File: hw/rtl/priority_failover_selector.sv
// Priority failover selector top level: joins controller, datapath and channels.
// A request is captured, then its counters are updated, then a failover walks the priority
// slots one by one (up to 8), and the result is registered once the output is free.
// A new request is taken only after the previous result is in the output register;
// the serial walk over the priority slots makes a request that triggers a failover take longer.
// Reset (rst_n, synchronous) clears all counters, selects provider 0 and loads
// the register defaults; no clearing pass follows.
`timescale 1ns / 1ps
module priority_failover_selector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data,
  pfs_evt_if.sink                        in_evt,
  pfs_res_if.source                      out_res
);
  import pfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_evt.valid),
    .in_ready  (in_evt.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfs_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_kind           (in_evt.kind),
    .in_provider_index (in_evt.provider_index),
    .cmd               (cmd),
    .sts               (sts),
    .res_active        (out_res.active_provider),
    .res_switched      (out_res.switched),
    .res_previous      (out_res.previous_provider),
    .res_known         (out_res.known),
    .res_run           (out_res.run_of_failures),
    .res_fsum          (out_res.failures_total),
    .res_ssum          (out_res.successes_total)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_evt.valid && in_evt.ready) |=> !in_evt.ready)
    else $error("request accepted while the previous one is still in work");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_res.valid)
    else $error("result register loaded without raising valid");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.known) |-> (out_res.run_of_failures == '0 &&
      out_res.failures_total == '0 && out_res.successes_total == '0))
    else $error("unknown provider reported nonzero counters");

  a_switch_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.switched ==
      (out_res.active_provider != out_res.previous_provider)))
    else $error("switched flag disagrees with provider change");

endmodule

// File: test/priority_failover_selector_tb.sv
// Self-checking testbench for the priority failover selector.
// Needs pfs_pkg, the pfs_evt_if and pfs_res_if channels and the top level.
// A built-in predictor tracks the provider counters and checks every result in order.
`timescale 1ns / 1ps
module priority_failover_selector_tb;
  import pfs_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int RESET_CYC  = 6;
  localparam int SETTLE_CYC = 16;
  localparam int HOLD_CYC   = 300;
  localparam int CYCLE_CAP  = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 41;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [RUN_W-1:0] RUN_SAT = 8'hFF;
  localparam logic [SUM_W-1:0] SUM_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [IDX_W-1:0] active;
    logic             switched;
    logic [IDX_W-1:0] prior;
    logic             known;
    logic [RUN_W-1:0] run;
    logic [SUM_W-1:0] fails;
    logic [SUM_W-1:0] wins;
  } health_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pfs_evt_if evt ();
  pfs_res_if res ();

  priority_failover_selector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_evt    (evt),
    .out_res   (res)
  );

  // Predictor state.
  logic [THR_W-1:0]  thr_q;
  logic [PCNT_W-1:0] count_q;
  logic [PRIO_W-1:0] prio_q;
  logic [RUN_W-1:0]  run_q [NUM_ENTRIES];
  logic [SUM_W-1:0]  fail_q [NUM_ENTRIES];
  logic [SUM_W-1:0]  win_q [NUM_ENTRIES];
  logic [IDX_W-1:0]  active_q;

  health_report_t pending_reports[$];
  int errors = 0;
  int requests_sent = 0;
  int switches_seen = 0;
  int unknown_seen = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic void clear_provider(int i);
    run_q[i] = '0;
    fail_q[i] = '0;
    win_q[i] = '0;
  endfunction

  task automatic reset_model();
    thr_q = THR_RESET;
    count_q = PCNT_RESET;
    prio_q = PRIO_RESET;
    for (int i = 0; i < NUM_ENTRIES; i++) clear_provider(i);
    active_q = '0;
  endtask

  function automatic health_report_t apply_event(kind_t k, logic [IDX_W-1:0] idx);
    health_report_t r;
    int live;
    bit known;
    bit found;
    logic [IDX_W-1:0] cand;
    live = (count_q > MAX_PROVIDERS) ? MAX_PROVIDERS : int'(count_q);
    known = int'(idx) < live;
    r.prior = active_q;
    if (k == KIND_RESET_ALL) begin
      for (int i = 0; i < NUM_ENTRIES; i++) clear_provider(i);
    end else if (known) begin
      case (k)
        KIND_SUCCESS: begin
          run_q[idx] = '0;
          if (win_q[idx] != SUM_SAT) win_q[idx]++;
        end
        KIND_FAILURE: begin
          if (run_q[idx] != RUN_SAT) run_q[idx]++;
          if (fail_q[idx] != SUM_SAT) fail_q[idx]++;
          if (run_q[idx] >= thr_q && idx == active_q) begin
            found = 1'b0;
            for (int s = 0; s < PRIO_SLOTS; s++) begin
              cand = prio_q[s*SLOT_W +: SLOT_W];
              if (!found && int'(cand) < live && cand != idx && run_q[cand] < thr_q) begin
                active_q = cand;
                found = 1'b1;
              end
            end
          end
        end
        default: clear_provider(idx);
      endcase
    end
    r.active = active_q;
    r.switched = active_q != r.prior;
    r.known = known;
    r.run = known ? run_q[idx] : '0;
    r.fails = known ? fail_q[idx] : '0;
    r.wins = known ? win_q[idx] : '0;
    return r;
  endfunction

  task automatic set_reg(logic [CFG_IDX_W-1:0] r, logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_THRESHOLD: thr_q = d[THR_W-1:0];
      REG_COUNT:     count_q = d[PCNT_W-1:0];
      REG_PRIORITY:  prio_q = d[PRIO_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(logic [THR_W-1:0] thr, logic [PCNT_W-1:0] cnt,
                           logic [PRIO_W-1:0] prio);
    set_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    set_reg(REG_COUNT, CFG_DATA_W'(cnt));
    set_reg(REG_PRIORITY, prio);
  endtask

  task automatic send_event(kind_t k, logic [IDX_W-1:0] idx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    evt.valid <= 1'b1;
    evt.kind <= k;
    evt.provider_index <= idx;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    pending_reports.insert(pending_reports.size(), apply_event(k, idx));
    requests_sent++;
  endtask

  task automatic drain();
    evt.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic random_event();
    int pick;
    kind_t k;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    idx = $urandom_range(0, 7);
    if (pick < 45) begin
      k = KIND_FAILURE;
      if ($urandom_range(0, 2) != 0) idx = active_q;
    end else if (pick < 80) begin
      k = KIND_SUCCESS;
    end else if (pick < 94) begin
      k = KIND_RESET_ONE;
    end else begin
      k = KIND_RESET_ALL;
    end
    send_event(k, idx);
  endtask

  task automatic test_reset_defaults();
    send_event(KIND_SUCCESS, 3'd0);
    send_event(KIND_FAILURE, 3'd7);
    drain();
  endtask

  task automatic test_basic_failover();
    configure(8'd3, 4'd8, PRIO_RESET);
    set_reg(REG_SPARE, CFG_DATA_W'($urandom));
    repeat (3) send_event(KIND_FAILURE, 3'd0);
    send_event(KIND_SUCCESS, 3'd1);
    send_event(KIND_RESET_ONE, 3'd0);
    send_event(KIND_FAILURE, 3'd7);
    send_event(KIND_RESET_ALL, 3'd5);
    send_event(KIND_SUCCESS, 3'd7);
    drain();
  endtask

  task automatic test_threshold_zero();
    set_reg(REG_THRESHOLD, '0);
    send_event(KIND_FAILURE, active_q);
    send_event(KIND_FAILURE, active_q);
    drain();
  endtask

  task automatic test_unregistered_active();
    configure(8'd1, 4'd15, 24'h00001D);
    send_event(KIND_RESET_ALL, 3'd0);
    send_event(KIND_FAILURE, active_q);
    drain();
    set_reg(REG_COUNT, 24'd3);
    send_event(KIND_FAILURE, 3'd5);
    send_event(KIND_SUCCESS, 3'd5);
    send_event(KIND_FAILURE, 3'd7);
    drain();
  endtask

  task automatic test_priority_slots();
    configure(8'd1, 4'd8, 24'h000001);
    send_event(KIND_FAILURE, active_q);
    drain();
    // Slots 0 to 5 name an unregistered provider, slots 6 and 7 both name provider 2.
    configure(8'd1, 4'd4, 24'h4BFFFF);
    send_event(KIND_FAILURE, active_q);
    send_event(KIND_FAILURE, active_q);
    drain();
    set_reg(REG_COUNT, '0);
    send_event(KIND_RESET_ONE, 3'd0);
    drain();
  endtask

  task automatic test_run_saturation();
    configure(8'd255, 4'd8, PRIO_RESET);
    send_event(KIND_RESET_ALL, 3'd0);
    repeat (257) send_event(KIND_FAILURE, 3'd0);
    send_event(KIND_SUCCESS, 3'd0);
    drain();
  endtask

  task automatic test_backpressure();
    configure(8'd2, 4'd8, CFG_DATA_W'($urandom));
    hold_req = 1'b1;
    repeat (40) random_event();
    drain();
  endtask

  task automatic test_random_traffic();
    logic [THR_W-1:0] thr;
    logic [PCNT_W-1:0] cnt;
    logic [PRIO_W-1:0] prio;
    for (int p = 0; p < RAND_PHASES; p++) begin
      thr = ($urandom_range(0, 5) == 0) ? 8'd0 : THR_W'($urandom_range(1, 4));
      cnt = PCNT_W'($urandom_range(2, 8));
      prio = PRIO_W'($urandom);
      if (p == 0) begin
        thr = 8'd255;
        cnt = 4'd15;
        prio = '0;
      end else if (p == 1) begin
        thr = 8'd1;
        cnt = 4'd8;
        prio = '1;
      end else if (p == 2) begin
        cnt = '0;
      end
      idle_on = (p != RAND_PHASES - 1);
      configure(thr, cnt, prio);
      repeat (PHASE_ITEMS) random_event();
      drain();
    end
  endtask

  initial begin : res_ready_gen
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    health_report_t want;
    if (rst_n && res.valid && res.ready) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual active %0d", $time,
                 res.active_provider);
      end else begin
        want = pending_reports.pop_front();
        if (res.switched) switches_seen++;
        if (!res.known) unknown_seen++;
        check_field("active_provider", want.active, res.active_provider);
        check_field("switched", want.switched, res.switched);
        check_field("previous_provider", want.prior, res.previous_provider);
        check_field("known", want.known, res.known);
        check_field("run_of_failures", want.run, res.run_of_failures);
        check_field("failures_total", want.fails, res.failures_total);
        check_field("successes_total", want.wins, res.successes_total);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    evt.valid <= 1'b0;
    evt.kind <= KIND_SUCCESS;
    evt.provider_index <= '0;
    reset_model();
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_basic_failover();
    test_threshold_zero();
    test_unregistered_active();
    test_priority_slots();
    test_run_saturation();
    test_backpressure();
    test_random_traffic();
    $display("Covered %0d requests with %0d provider switches and %0d unknown providers,",
             requests_sent, switches_seen, unknown_seen);
    $display("across threshold, provider count and priority settings including extremes.");
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
